// File: rtl/mandelbrot_escape_time_unit_assert.svh
// assertion macros for the escape-time unit checker
`ifndef MANDELBROT_ESCAPE_TIME_UNIT_ASSERT_SVH
`define MANDELBROT_ESCAPE_TIME_UNIT_ASSERT_SVH

// same-cycle implication, held off during reset
`define MET_CHECK_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off during reset
`define MET_CHECK_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

// condition that must hold in the cycle after reset is applied
`define MET_CHECK_RST(lbl, cons, msg) \
    lbl: assert property (@(posedge aclk) !aresetn |=> (cons)) else $error(msg);

`endif

// File: rtl/met_pkg.sv
// shared types, constants and helpers for the escape-time unit
`default_nettype none

package met_pkg;

    // fixed-point and field widths
    localparam int Q_W     = 32;
    localparam int STEP_W  = 31;
    localparam int LIM_W   = 16;
    localparam int PIX_W   = 12;
    localparam int FRAC_W  = 28;
    localparam int MUL_W   = 33;
    localparam int PROD_W  = 64;
    localparam int SUM_W   = 48;
    localparam int SQ_W    = PROD_W - FRAC_W;
    localparam int XP_W    = PROD_W - FRAC_W + 1;
    localparam int CFG_W   = 32;
    localparam int CIDX_W  = 3;

    // configuration register indexes
    localparam logic [CIDX_W-1:0] REG_REAL_ORIGIN = 3'd0;
    localparam logic [CIDX_W-1:0] REG_REAL_STEP   = 3'd1;
    localparam logic [CIDX_W-1:0] REG_IMAG_ORIGIN = 3'd2;
    localparam logic [CIDX_W-1:0] REG_IMAG_STEP   = 3'd3;
    localparam logic [CIDX_W-1:0] REG_ITER_LIMIT  = 3'd4;

    // escape radius squared, 4.0 in Q4.28
    localparam logic signed [SUM_W-1:0] ESCAPE_RAW = 48'sd1073741824;
    localparam logic signed [SUM_W-1:0] Q_MAX      = 48'sd2147483647;
    localparam logic signed [SUM_W-1:0] Q_MIN      = -48'sd2147483648;

    // operand selection of the shared multiplier
    typedef enum logic [2:0] {
        OP_COL,
        OP_ROW,
        OP_ZRR,
        OP_ZII,
        OP_ZRI,
        OP_CNT
    } op_t;

    // control from the sequencer to the datapath
    typedef struct packed {
        op_t  op;
        logic load_cr;
        logic load_ci;
        logic load_zr2;
        logic load_zi2;
        logic clear_z;
        logic update_z;
    } ctl_t;

    // clamp a wide sum to the signed Q4.28 range
    function automatic logic signed [Q_W-1:0] sat_q(input logic signed [SUM_W-1:0] v);
        logic signed [Q_W-1:0] r;
        if (v > Q_MAX) begin
            r = 32'sh7FFFFFFF;
        end else if (v < Q_MIN) begin
            r = 32'sh80000000;
        end else begin
            r = Q_W'(v);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: rtl/mandelbrot_escape_time_unit.sv
// top level of the escape-time unit: channels, configuration and output register
//
// One pixel coordinate enters on the s_ channel; one result leaves on the m_ channel.
// The unit maps the pixel to a point c in Q4.28 from the configured origins and
// steps, then iterates z = z*z + c from zero until |z|^2 reaches 4.0 or the
// iteration limit is reached, and reports the count and a blue byte (count
// squared, low eight bits).
// Every product goes through one shared 33x33 multiplier, three times per
// iteration (the two squares and the cross term), before z is updated.
// s_tready is low while a pixel is being worked on; the next pixel is taken
// while the previous result still waits in the output register.
// If the receiver stalls, the finished result waits in the sequencer until the
// output register is free, adding the stalled cycles to the pixel.
// Synchronous reset returns the sequencer to idle, drops m_tvalid and loads
// the configuration defaults. Configuration writes belong to idle periods.
`default_nettype none

module mandelbrot_escape_time_unit #(
    parameter int COORD_BITS = 12,
    parameter int COUNT_BITS = 16
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // configuration write port
    input  wire logic                          cfg_wr_en,
    input  wire logic [met_pkg::CIDX_W-1:0]    cfg_index,
    input  wire logic [met_pkg::CFG_W-1:0]     cfg_wr_data,
    // pixel input: pixel_col [11:0], pixel_row [23:12]
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [23:0]                   s_tdata,
    // result output: escape_count [15:0], blue_level [23:16]
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [23:0]                        m_tdata
);
    import met_pkg::*;

    localparam int CNT_W = (COUNT_BITS < LIM_W) ? COUNT_BITS : LIM_W;
    localparam logic [LIM_W-1:0] CNT_MAX = LIM_W'((64'd1 << CNT_W) - 64'd1);
    localparam logic [PIX_W-1:0] COORD_MASK =
        (COORD_BITS >= PIX_W) ? {PIX_W{1'b1}} : PIX_W'((64'd1 << COORD_BITS) - 64'd1);

    logic signed [Q_W-1:0]  real_origin_reg, imag_origin_reg;
    logic [STEP_W-1:0]      real_step_reg, imag_step_reg;
    logic [LIM_W-1:0]       limit_reg;
    logic [PIX_W-1:0]       col_reg, row_reg;
    logic                   m_tvalid_reg;
    logic [23:0]            m_tdata_reg;
    logic [LIM_W-1:0]       lim_clip;
    logic                   busy, done, escape, out_free, s_xfer;
    ctl_t                   ctl;
    logic [LIM_W-1:0]       count;
    logic [7:0]             cnt_lo, blue;

    assign s_tready = !busy;
    assign s_xfer   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign lim_clip = (limit_reg > CNT_MAX) ? CNT_MAX : limit_reg;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            real_origin_reg <= 32'shE0000000;
            real_step_reg   <= 31'd196608;
            imag_origin_reg <= 32'shF0000000;
            imag_step_reg   <= 31'd131072;
            limit_reg       <= 16'd255;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_REAL_ORIGIN: real_origin_reg <= cfg_wr_data;
                REG_REAL_STEP:   real_step_reg   <= cfg_wr_data[STEP_W-1:0];
                REG_IMAG_ORIGIN: imag_origin_reg <= cfg_wr_data;
                REG_IMAG_STEP:   imag_step_reg   <= cfg_wr_data[STEP_W-1:0];
                REG_ITER_LIMIT:  limit_reg       <= cfg_wr_data[LIM_W-1:0];
                default: ;
            endcase
        end
    end

    // capture the pixel on its transfer
    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            col_reg <= s_tdata[PIX_W-1:0] & COORD_MASK;
            row_reg <= s_tdata[2*PIX_W-1:PIX_W] & COORD_MASK;
        end
    end

    met_seq #(
        .CNT_W (CNT_W)
    ) u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start_i    (s_xfer),
        .lim_i      (CNT_W'(lim_clip)),
        .escape_i   (escape),
        .out_free_i (out_free),
        .busy_o     (busy),
        .done_o     (done),
        .ctl_o      (ctl),
        .count_o    (count),
        .cnt_lo_o   (cnt_lo)
    );

    met_dp u_dp (
        .aclk          (aclk),
        .ctl_i         (ctl),
        .col_i         (col_reg),
        .row_i         (row_reg),
        .real_origin_i (real_origin_reg),
        .real_step_i   (real_step_reg),
        .imag_origin_i (imag_origin_reg),
        .imag_step_i   (imag_step_reg),
        .cnt_lo_i      (cnt_lo),
        .escape_o      (escape),
        .blue_o        (blue)
    );

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (done) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (done) begin
            m_tdata_reg <= {blue, count};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

// File: rtl/met_mul.sv
// shared signed multiplier used for mapping, squares, cross term and colour
`default_nettype none

module met_mul (
    input  wire logic signed [met_pkg::MUL_W-1:0]  a_i,
    input  wire logic signed [met_pkg::MUL_W-1:0]  b_i,
    output logic signed      [met_pkg::PROD_W-1:0] p_o
);
    import met_pkg::*;

    logic signed [2*MUL_W-1:0] full;

    // all products in use fit in 64 bits
    assign full = a_i * b_i;
    assign p_o  = full[PROD_W-1:0];

endmodule

`default_nettype wire

// File: rtl/met_seq.sv
// sequencer: steps one pixel through mapping, iterations and result hand-off
`default_nettype none

module met_seq #(
    parameter int CNT_W = 16
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              start_i,
    input  wire logic [CNT_W-1:0]  lim_i,
    input  wire logic              escape_i,
    input  wire logic              out_free_i,
    output logic                   busy_o,
    output logic                   done_o,
    output met_pkg::ctl_t          ctl_o,
    output logic [met_pkg::LIM_W-1:0] count_o,
    output logic [7:0]             cnt_lo_o
);
    import met_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MAP_R,
        S_MAP_I,
        S_MAP_C,
        S_SQ_R,
        S_SQ_I,
        S_CROSS,
        S_UPDATE,
        S_DONE
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  count_inc;

    assign count_inc = count_reg + CNT_W'(1);

    // next state, counter and datapath strobes
    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        ctl_o      = '{op: OP_COL, default: 1'b0};
        done_o     = 1'b0;
        case (state_reg)
            S_IDLE: begin
                if (start_i) begin
                    count_next = '0;
                    state_next = S_MAP_R;
                end
            end
            S_MAP_R: begin
                ctl_o.op   = OP_COL;
                state_next = S_MAP_I;
            end
            S_MAP_I: begin
                ctl_o.op      = OP_ROW;
                ctl_o.load_cr = 1'b1;
                state_next    = S_MAP_C;
            end
            S_MAP_C: begin
                ctl_o.load_ci = 1'b1;
                ctl_o.clear_z = 1'b1;
                state_next    = (count_reg < lim_i) ? S_SQ_R : S_DONE;
            end
            S_SQ_R: begin
                ctl_o.op   = OP_ZRR;
                state_next = S_SQ_I;
            end
            S_SQ_I: begin
                ctl_o.op       = OP_ZII;
                ctl_o.load_zr2 = 1'b1;
                state_next     = S_CROSS;
            end
            S_CROSS: begin
                ctl_o.op       = OP_ZRI;
                ctl_o.load_zi2 = 1'b1;
                state_next     = escape_i ? S_DONE : S_UPDATE;
            end
            S_UPDATE: begin
                ctl_o.update_z = 1'b1;
                count_next     = count_inc;
                state_next     = (count_inc < lim_i) ? S_SQ_R : S_DONE;
            end
            S_DONE: begin
                ctl_o.op = OP_CNT;
                if (out_free_i) begin
                    done_o     = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and iteration counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    assign busy_o   = (state_reg != S_IDLE);
    assign count_o  = LIM_W'(count_reg);
    assign cnt_lo_o = 8'(count_reg);

endmodule

`default_nettype wire

// File: rtl/met_dp.sv
// datapath: point registers, iterate registers and the product register
`default_nettype none

module met_dp (
    input  wire logic                           aclk,
    input  wire met_pkg::ctl_t                  ctl_i,
    input  wire logic [met_pkg::PIX_W-1:0]      col_i,
    input  wire logic [met_pkg::PIX_W-1:0]      row_i,
    input  wire logic signed [met_pkg::Q_W-1:0] real_origin_i,
    input  wire logic [met_pkg::STEP_W-1:0]     real_step_i,
    input  wire logic signed [met_pkg::Q_W-1:0] imag_origin_i,
    input  wire logic [met_pkg::STEP_W-1:0]     imag_step_i,
    input  wire logic [7:0]                     cnt_lo_i,
    output logic                                escape_o,
    output logic [7:0]                          blue_o
);
    import met_pkg::*;

    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0] mul_p;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [Q_W-1:0]    cr_reg, ci_reg, zr_reg, zi_reg;
    logic signed [SQ_W-1:0]   zr2_reg, zi2_reg;
    logic signed [SQ_W-1:0]   sq_w;
    logic signed [XP_W-1:0]   cross_w;
    logic signed [SUM_W-1:0]  mag_w;

    // operand selection for the shared multiplier
    always_comb begin
        case (ctl_i.op)
            OP_COL: begin
                mul_a = MUL_W'(col_i);
                mul_b = MUL_W'(real_step_i);
            end
            OP_ROW: begin
                mul_a = MUL_W'(row_i);
                mul_b = MUL_W'(imag_step_i);
            end
            OP_ZRR: begin
                mul_a = MUL_W'(zr_reg);
                mul_b = MUL_W'(zr_reg);
            end
            OP_ZII: begin
                mul_a = MUL_W'(zi_reg);
                mul_b = MUL_W'(zi_reg);
            end
            OP_ZRI: begin
                mul_a = MUL_W'(zr_reg);
                mul_b = MUL_W'(zi_reg);
            end
            OP_CNT: begin
                mul_a = MUL_W'(cnt_lo_i);
                mul_b = MUL_W'(cnt_lo_i);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    met_mul u_mul (
        .a_i (mul_a),
        .b_i (mul_b),
        .p_o (mul_p)
    );

    // floored shifts of the registered product
    assign sq_w    = prod_reg[PROD_W-1:FRAC_W];
    assign cross_w = prod_reg[PROD_W-1:FRAC_W-1];

    // escape test on the two squares
    assign mag_w    = SUM_W'(zr2_reg) + SUM_W'(sq_w);
    assign escape_o = (mag_w >= ESCAPE_RAW);

    // colour byte straight from the multiplier when the count is selected
    assign blue_o = mul_p[7:0];

    // product and iterate registers
    always_ff @(posedge aclk) begin
        prod_reg <= mul_p;
        if (ctl_i.load_cr) begin
            cr_reg <= sat_q(SUM_W'(real_origin_i) + SUM_W'(prod_reg));
        end
        if (ctl_i.load_ci) begin
            ci_reg <= sat_q(SUM_W'(imag_origin_i) + SUM_W'(prod_reg));
        end
        if (ctl_i.load_zr2) begin
            zr2_reg <= sq_w;
        end
        if (ctl_i.load_zi2) begin
            zi2_reg <= sq_w;
        end
        if (ctl_i.clear_z) begin
            zr_reg <= '0;
            zi_reg <= '0;
        end else if (ctl_i.update_z) begin
            zr_reg <= sat_q(SUM_W'(zr2_reg) - SUM_W'(zi2_reg) + SUM_W'(cr_reg));
            zi_reg <= sat_q(SUM_W'(cross_w) + SUM_W'(ci_reg));
        end
    end

endmodule

`default_nettype wire

// File: rtl/met_checker.sv
// port-level checker for the escape-time unit, bound to the top level
`default_nettype none

`include "mandelbrot_escape_time_unit_assert.svh"

module met_checker (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [23:0] m_tdata
);

    // a stalled result holds
    `MET_CHECK_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")

    // blue byte always matches the count shown
    `MET_CHECK_IMP(a_blue, m_tvalid, m_tdata[23:16] == 8'(16'(m_tdata[7:0]) * 16'(m_tdata[7:0])), "blue level does not match count")

    // the unit is busy in the cycle after taking a pixel
    `MET_CHECK_NXT(a_busy, s_tvalid && s_tready, !s_tready, "input ready right after a transfer")

    // reset leaves the unit idle with no result pending
    `MET_CHECK_RST(a_reset, s_tready && !m_tvalid, "unit not idle after reset")

endmodule

bind mandelbrot_escape_time_unit met_checker u_met_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
